// File: sv/mtt_pkg.sv
// shared types, morse code tables and helper functions for the text transcoder
`default_nettype none

package mtt_pkg;

    localparam int CODE_COUNT  = 36;
    localparam int MAX_RESULTS = 6;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_QUEST = 8'h3F;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UZ    = 8'h5A;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    localparam logic [5:0] IDX_DIGIT1 = 6'd26;
    localparam logic [5:0] IDX_DIGIT0 = 6'd35;

    // a..z, then 1..9, then 0; bit i of the pattern set means symbol i is a dash
    localparam logic [2:0] CODE_LEN [CODE_COUNT] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    localparam logic [4:0] CODE_BITS [CODE_COUNT] = '{
        5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14, 5'd5, 5'd2, 5'd3,
        5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3,
        5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15, 5'd31
    };

    // results produced by one input byte, entry 0 goes out first
    typedef struct packed {
        logic [2:0]                   count;
        logic                         eom;
        logic [MAX_RESULTS-1:0][7:0]  chars;
    } mtt_job_t;

    function automatic logic [7:0] code_char(input int i);
        logic [7:0] ch;
        if (i < 26) begin
            ch = 8'(int'(CHAR_UA) + i);
        end else if (i < 35) begin
            ch = 8'(int'(CHAR_ONE) + i - 26);
        end else begin
            ch = CHAR_ZERO;
        end
        return ch;
    endfunction

    function automatic logic [7:0] decode_store(input logic [2:0] cnt, input logic [6:0] bits);
        logic [7:0] ch;
        ch = CHAR_QUEST;
        for (int i = 0; i < CODE_COUNT; i++) begin
            if (CODE_LEN[i] == cnt && {2'b00, CODE_BITS[i]} == bits) begin
                ch = code_char(i);
            end
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: sv/morse_text_transcoder_core.sv
// top level of the morse text transcoder: byte decoder feeding the result queue
// latency: the first result of a byte is valid the cycle after the byte transfer
// throughput: a byte's results (up to 6 for a digit) go out one per cycle while m_ready
// is high; the input takes the next byte with the last transfer, or stays ready after no result
// reset: clears the symbol store, the message length and any queued results
`default_nettype none

module morse_text_transcoder_core #(
    parameter int MESSAGE_CAPACITY = 256,
    parameter int MAX_SYMBOLS      = 7
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_end_of_message,
    output logic             m_last
);
    import mtt_pkg::*;

    mtt_job_t job;
    logic     accept;

    assign accept = s_valid && s_ready;

    mtt_decode #(
        .MESSAGE_CAPACITY (MESSAGE_CAPACITY),
        .MAX_SYMBOLS      (MAX_SYMBOLS)
    ) u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .job     (job)
    );

    mtt_emit u_emit (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (accept),
        .job              (job),
        .load_ready       (s_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_char       (m_out_char),
        .m_end_of_message (m_end_of_message),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire

// File: sv/mtt_decode.sv
// byte decoder: symbol store, message length and the result list for each byte
`default_nettype none

module mtt_decode #(
    parameter int MESSAGE_CAPACITY = 256,
    parameter int MAX_SYMBOLS      = 7
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic [7:0]       in_byte,
    output mtt_pkg::mtt_job_t     job
);
    import mtt_pkg::*;

    localparam int LEN_W = $clog2(MESSAGE_CAPACITY);

    logic [6:0]       sym_bits_reg, sym_bits_next;
    logic [2:0]       sym_count_reg, sym_count_next;
    logic [LEN_W-1:0] msg_len_reg, msg_len_next;

    logic [7:0]       up_char;
    logic [5:0]       idx;
    logic             is_code;
    logic [2:0]       len;
    logic [MAX_RESULTS-1:0] pat;
    logic [LEN_W:0]   len_sum;
    logic             sep_room;
    logic             code_room;
    logic [7:0]       sep_char;

    always_comb begin
        up_char = in_byte;
        if (in_byte >= CHAR_LA && in_byte <= CHAR_LZ) begin
            up_char = in_byte - CASE_DIFF;
        end
        is_code = 1'b1;
        idx     = '0;
        if (up_char >= CHAR_UA && up_char <= CHAR_UZ) begin
            idx = 6'(up_char - CHAR_UA);
        end else if (up_char >= CHAR_ONE && up_char <= CHAR_NINE) begin
            idx = IDX_DIGIT1 + 6'(up_char - CHAR_ONE);
        end else if (up_char == CHAR_ZERO) begin
            idx = IDX_DIGIT0;
        end else begin
            is_code = 1'b0;
        end
        len       = CODE_LEN[idx];
        pat       = {1'b0, CODE_BITS[idx]};
        len_sum   = {1'b0, msg_len_reg} + (LEN_W+1)'(len) + (LEN_W+1)'(1);
        code_room = len_sum < (LEN_W+1)'(MESSAGE_CAPACITY);
        sep_room  = {1'b0, msg_len_reg} < (LEN_W+1)'(MESSAGE_CAPACITY - 1);
        sep_char  = (sym_count_reg != 3'd0) ? decode_store(sym_count_reg, sym_bits_reg)
                                            : CHAR_SPACE;
    end

    always_comb begin
        sym_bits_next  = sym_bits_reg;
        sym_count_next = sym_count_reg;
        msg_len_next   = msg_len_reg;
        job.count      = 3'd0;
        job.eom        = 1'b0;
        job.chars      = '0;
        if (in_byte == CHAR_DOT || in_byte == CHAR_DASH) begin
            if (sym_count_reg < 3'(MAX_SYMBOLS)) begin
                if (in_byte == CHAR_DASH) begin
                    sym_bits_next = sym_bits_reg | (7'd1 << sym_count_reg);
                end
                sym_count_next = sym_count_reg + 3'd1;
            end
        end else if (in_byte == CHAR_SPACE) begin
            sym_bits_next  = '0;
            sym_count_next = 3'd0;
            if (sep_room) begin
                job.count    = 3'd1;
                job.chars[0] = sep_char;
                msg_len_next = msg_len_reg + LEN_W'(1);
            end
        end else if (in_byte == CHAR_LF || in_byte == CHAR_CR) begin
            sym_bits_next  = '0;
            sym_count_next = 3'd0;
            msg_len_next   = '0;
            job.eom        = 1'b1;
            if (sym_count_reg != 3'd0 && sep_room) begin
                job.count    = 3'd2;
                job.chars[0] = sep_char;
                job.chars[1] = CHAR_NUL;
            end else begin
                job.count    = 3'd1;
                job.chars[0] = CHAR_NUL;
            end
        end else if (is_code && code_room) begin
            job.count    = len + 3'd1;
            msg_len_next = LEN_W'(len_sum);
            for (int j = 0; j < MAX_RESULTS; j++) begin
                if (3'(j) < len) begin
                    job.chars[j] = pat[j] ? CHAR_DASH : CHAR_DOT;
                end else if (3'(j) == len) begin
                    job.chars[j] = CHAR_SPACE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_bits_reg  <= '0;
            sym_count_reg <= '0;
            msg_len_reg   <= '0;
        end else if (accept) begin
            sym_bits_reg  <= sym_bits_next;
            sym_count_reg <= sym_count_next;
            msg_len_reg   <= msg_len_next;
        end
    end

    // store never holds more symbols than allowed, and unused bits stay clear
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        sym_count_reg <= 3'(MAX_SYMBOLS))
        else $error("symbol count above limit");

    a_bits_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (sym_bits_reg >> sym_count_reg) == 7'd0)
        else $error("symbol bits set above count");

    a_len_max: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, msg_len_reg} < (LEN_W+1)'(MESSAGE_CAPACITY))
        else $error("message length beyond capacity");

endmodule

`default_nettype wire

// File: sv/mtt_emit.sv
// result queue: holds one byte's results and sends them one per cycle while m_ready is high
`default_nettype none

module mtt_emit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire mtt_pkg::mtt_job_t job,
    output logic                   load_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_out_char,
    output logic                   m_end_of_message,
    output logic                   m_last
);
    import mtt_pkg::*;

    logic [2:0]                  count_reg, count_next;
    logic                        eom_reg, eom_next;
    logic [MAX_RESULTS-1:0][7:0] chars_reg, chars_next;
    logic                        xfer;

    assign m_valid          = count_reg != 3'd0;
    assign m_last           = count_reg == 3'd1;
    assign m_out_char       = chars_reg[0];
    assign m_end_of_message = eom_reg && m_last;
    assign xfer             = m_valid && m_ready;
    assign load_ready       = !m_valid || (m_last && m_ready);

    always_comb begin
        count_next = count_reg;
        eom_next   = eom_reg;
        chars_next = chars_reg;
        if (load) begin
            count_next = job.count;
            eom_next   = job.eom;
            chars_next = job.chars;
        end else if (xfer) begin
            count_next = count_reg - 3'd1;
            chars_next = {8'h00, chars_reg[MAX_RESULTS-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            eom_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            eom_reg   <= eom_next;
        end
    end

    always_ff @(posedge aclk) begin
        chars_reg <= chars_next;
    end

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(MAX_RESULTS))
        else $error("result count above limit");

    a_eom_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_message |-> m_out_char == CHAR_NUL)
        else $error("end marker carries a character");

    a_load_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        load && m_valid |-> m_last && m_ready)
        else $error("new byte loaded over pending results");

endmodule

`default_nettype wire
